@@ sv/qre_pkg.sv @@
`timescale 1ns / 1ps

package qre_pkg;

	localparam int MAX_COLORS_DEF = 64;
	localparam int VALUE_BITS_DEF = 32;

	localparam int CFG_W     = 7;
	localparam int FUNC_W    = 2;
	localparam int SAMPLE_W  = 32;
	localparam int IDX_W     = 31;
	localparam int COLOR_W   = 6;
	localparam int S_DATA_W  = 96;
	localparam int M_DATA_W  = 96;

	localparam logic [CFG_W-1:0] COLORS_RESET = 7'd16;
	localparam logic [IDX_W-1:0] LEN_MAX      = {IDX_W{1'b1}};

	localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] len;
	} run_t;

endpackage

@@ sv/qre_div.sv @@
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle. The numerator is shifted in
// bit by bit behind a remainder that always stays below the divisor.
module qre_div
	import qre_pkg::*;
#(
	parameter int VB = VALUE_BITS_DEF,
	parameter int QW = $clog2(MAX_COLORS_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VB+QW-1:0] num,
	input  logic [VB-1:0]    den,
	output logic             done,
	output logic [QW-1:0]    quo
);

	localparam int CNT_W = $clog2(QW + 1);

	logic [VB-1:0]    rem_q;
	logic [QW-1:0]    num_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [VB:0]      trial;
	logic             fits;

	assign trial = {rem_q, num_q[QW-1]};
	assign fits  = trial >= {1'b0, den};
	assign done  = busy_q && (cnt_q == CNT_W'(QW - 1));
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient is known to fit QW bits, so the high part is already below den
			rem_q <= num[VB+QW-1:QW];
			num_q <= num[QW-1:0];
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= VB'(trial - {1'b0, den});
			end else begin
				rem_q <= trial[VB-1:0];
			end
			num_q <= QW'({num_q, 1'b0});
			quo_q <= QW'({quo_q, fits});
		end
	end

endmodule

@@ sv/quantized_run_length_encoder_top.sv @@
`timescale 1ns / 1ps

// Quantized run-length encoder.
// Input stream s_*: s_tuser carries func (scan, entry, flush); s_tdata carries
// sample value, row and column. Scan requests raise the running maximum; entry
// requests are binned as floor(value * (colors - 1) / max) and grow or restart
// that color's open run; flush requests emit all open runs in color order,
// with m_tlast on the final one, and clear the runs and the maximum.
// Output stream m_*: m_tuser carries the color, m_tdata row, start column and
// length. Write cfg_wdata with cfg_we to set the color count while idle.
// Scan, ignored and dropped requests leave the block idle. An entry steps
// through capture, multiply, the serial divider at one quotient bit per cycle,
// then a read and a write of the per-color run memory; a value at or above the
// maximum skips the divider. A flush steps through the colors in order up to the
// highest open one and emits each open run on its way. m_tdata is registered:
// a run reaches it in the cycle after it is loaded.
// The output register holds one run; new requests are taken while it waits,
// and the block stalls only when it must emit while the register is full.
// Reset clears the maximum, all open flags, the output valid and sets the
// color count to 16; the run memory itself needs no clearing.
module quantized_run_length_encoder_top
	import qre_pkg::*;
#(
	parameter int MAX_COLORS = MAX_COLORS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // sample value, row, column
	input  logic [FUNC_W-1:0]   s_tuser,   // func
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // run_row, run_start_col, run_length
	output logic [COLOR_W-1:0]  m_tuser,   // color
	output logic                m_tlast
);

	localparam int VB    = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
	localparam int BIN_W = $clog2(MAX_COLORS);
	localparam int CNT_W = $clog2(MAX_COLORS + 1);
	localparam int PW    = VB + BIN_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_LOOK  = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_FSCAN = 3'd5;
	localparam logic [2:0] ST_FEMIT = 3'd6;

	logic [2:0]            state_q;
	logic [CFG_W-1:0]      colors_q;
	logic [VB-1:0]         max_q;
	logic [VB-1:0]         v_q;
	logic [IDX_W-1:0]      row_q;
	logic [IDX_W-1:0]      col_q;
	logic [BIN_W-1:0]      cm1_q;
	logic                  ge_q;
	logic [MAX_COLORS-1:0] flag_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [BIN_W-1:0]      idx_q;

	run_t                  mem [MAX_COLORS];
	run_t                  rd_q;
	logic                  rd_en;
	logic [BIN_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [BIN_W-1:0]      wr_addr;
	run_t                  wr_data;

	logic                  m_valid_q;
	logic [COLOR_W-1:0]    m_color_q;
	run_t                  m_run_q;
	logic                  m_last_q;
	logic                  out_free;
	logic                  out_load;
	logic [COLOR_W-1:0]    out_color;
	logic                  out_last;

	logic                  accept;
	logic [VB-1:0]         v_w;
	logic [CFG_W-1:0]      ce_w;
	logic [BIN_W-1:0]      cm1_w;
	logic [PW-1:0]         prod;
	logic                  ge_w;
	logic                  div_start;
	logic                  div_done;
	logic [BIN_W-1:0]      quo;
	logic [BIN_W-1:0]      bin_w;
	logic                  hit;
	logic [IDX_W:0]        run_end;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign v_w      = s_tdata[VB-1:0];

	always_comb begin
		ce_w = colors_q;
		if (colors_q == '0) begin
			ce_w = CFG_W'(1);
		end else if (colors_q > CFG_W'(MAX_COLORS)) begin
			ce_w = CFG_W'(MAX_COLORS);
		end
		cm1_w = BIN_W'(ce_w - CFG_W'(1));
	end

	assign prod      = PW'(v_q) * PW'(cm1_q);
	assign ge_w      = v_q >= max_q;
	assign div_start = (state_q == ST_MUL) && !ge_w;

	qre_div #(
		.VB (VB),
		.QW (BIN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (max_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign bin_w   = ge_q ? cm1_q : quo;
	assign run_end = {1'b0, rd_q.col} + {1'b0, rd_q.len};
	assign hit     = flag_q[bin_w] && (rd_q.row == row_q) && (run_end == {1'b0, col_q});

	assign out_free = !m_valid_q || m_tready;

	// memory ports and output load
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = bin_w;
		wr_en     = 1'b0;
		wr_addr   = bin_w;
		wr_data   = '{row: row_q, col: col_q, len: IDX_W'(1)};
		out_load  = 1'b0;
		out_color = COLOR_W'(bin_w);
		out_last  = 1'b0;
		case (state_q)
			ST_LOOK: begin
				rd_en = 1'b1;
			end
			ST_UPD: begin
				if (hit) begin
					wr_en   = 1'b1;
					wr_data = rd_q;
					if (rd_q.len != LEN_MAX) begin
						wr_data.len = rd_q.len + IDX_W'(1);
					end
				end else if (!flag_q[bin_w] || out_free) begin
					wr_en    = 1'b1;
					out_load = flag_q[bin_w];
				end
			end
			ST_FSCAN: begin
				rd_addr = idx_q;
				rd_en   = flag_q[idx_q];
			end
			ST_FEMIT: begin
				out_color = COLOR_W'(idx_q);
				out_last  = (cnt_q == CNT_W'(1));
				out_load  = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q <= COLORS_RESET;
		end else if (cfg_we) begin
			colors_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q   <= '0;
			flag_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							FUNC_SCAN: begin
								if (v_w > max_q) begin
									max_q <= v_w;
								end
							end
							FUNC_ENTRY: begin
								// drop entries while no maximum is known
								if (max_q != '0) begin
									state_q <= ST_MUL;
								end
							end
							FUNC_FLUSH: begin
								max_q <= '0;
								idx_q <= '0;
								if (cnt_q != '0) begin
									state_q <= ST_FSCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ge_w ? ST_LOOK : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (hit) begin
						state_q <= ST_IDLE;
					end else if (!flag_q[bin_w] || out_free) begin
						if (!flag_q[bin_w]) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						flag_q[bin_w] <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_FSCAN: begin
					if (flag_q[idx_q]) begin
						state_q <= ST_FEMIT;
					end else begin
						idx_q <= idx_q + BIN_W'(1);
					end
				end
				ST_FEMIT: begin
					if (out_free) begin
						flag_q[idx_q] <= 1'b0;
						cnt_q         <= cnt_q - CNT_W'(1);
						idx_q         <= idx_q + BIN_W'(1);
						state_q       <= (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_FSCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the entry operands
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= v_w;
			row_q <= s_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
			col_q <= s_tdata[SAMPLE_W+2*IDX_W-1:SAMPLE_W+IDX_W];
			cm1_q <= cm1_w;
		end
		if (state_q == ST_MUL) begin
			ge_q <= ge_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_color_q <= out_color;
			m_run_q   <= rd_q;
			m_last_q  <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_color_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(M_DATA_W - 3*IDX_W){1'b0}}, m_run_q.len, m_run_q.col, m_run_q.row};

endmodule

@@ dv/qre_run_checker.sv @@
`timescale 1ns / 1ps

module qre_run_checker
	import qre_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [FUNC_W-1:0]   s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic [COLOR_W-1:0]  m_tuser,
	input  logic                m_tlast,
	output int                  errors,
	output int                  runs_due_count
);

	typedef struct {
		logic [COLOR_W-1:0] color;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [IDX_W-1:0]   len;
		logic               last;
	} run_rec_t;

	run_rec_t           runs_due[$];
	run_rec_t           want;
	logic [CFG_W-1:0]   colors;
	logic [SAMPLE_W-1:0] peak;
	logic               open_q[MAX_COLORS_DEF];
	run_t               open_run[MAX_COLORS_DEF];

	function automatic int bin_of(logic [SAMPLE_W-1:0] v);
		int          eff;
		logic [63:0] prod;
		eff = int'(colors);
		if (eff < 1)
			eff = 1;
		if (eff > MAX_COLORS_DEF)
			eff = MAX_COLORS_DEF;
		if (v >= peak)
			return eff - 1;
		prod = 64'(v) * 64'(eff - 1);
		return int'(prod / 64'(peak));
	endfunction

	function automatic run_rec_t close_run(int b, logic last);
		run_rec_t r;
		r.color = COLOR_W'(b);
		r.row   = open_run[b].row;
		r.col   = open_run[b].col;
		r.len   = open_run[b].len;
		r.last  = last;
		return r;
	endfunction

	task automatic take_request(logic [FUNC_W-1:0] func, logic [S_DATA_W-1:0] data);
		logic [SAMPLE_W-1:0] v;
		logic [IDX_W-1:0]    row;
		logic [IDX_W-1:0]    col;
		int                  b;
		int                  last_b;
		v   = data[31:0];
		row = data[62:32];
		col = data[93:63];
		case (func)
			FUNC_SCAN: begin
				if (v > peak)
					peak = v;
			end
			FUNC_ENTRY: begin
				// drop entries while no maximum is known
				if (peak != '0) begin
					b = bin_of(v);
					if (open_q[b] && open_run[b].row == row &&
					    {1'b0, open_run[b].col} + {1'b0, open_run[b].len} == {1'b0, col}) begin
						if (open_run[b].len != LEN_MAX)
							open_run[b].len = open_run[b].len + 1'b1;
					end else begin
						if (open_q[b])
							runs_due.push_back(close_run(b, 1'b0));
						open_q[b]         = 1'b1;
						open_run[b].row   = row;
						open_run[b].col   = col;
						open_run[b].len   = IDX_W'(1);
					end
				end
			end
			FUNC_FLUSH: begin
				last_b = -1;
				for (int i = 0; i < MAX_COLORS_DEF; i++)
					if (open_q[i])
						last_b = i;
				for (int i = 0; i < MAX_COLORS_DEF; i++) begin
					if (open_q[i]) begin
						runs_due.push_back(close_run(i, i == last_b));
						open_q[i] = 1'b0;
					end
				end
				peak = '0;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors = COLORS_RESET;
			peak   = '0;
			errors = 0;
			for (int i = 0; i < MAX_COLORS_DEF; i++)
				open_q[i] = 1'b0;
			runs_due.delete();
		end else begin
			if (cfg_we)
				colors = cfg_wdata;
			if (s_tvalid && s_tready)
				take_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (runs_due.size() == 0) begin
					$error("unexpected run: color %0d row 0x%0h col 0x%0h len %0d",
					       m_tuser, m_tdata[30:0], m_tdata[61:31], m_tdata[92:62]);
					errors++;
				end else begin
					want = runs_due.pop_front();
					check_field("color", 32'(want.color), 32'(m_tuser));
					check_field("run_row", 32'(want.row), 32'(m_tdata[30:0]));
					check_field("run_start_col", 32'(want.col), 32'(m_tdata[61:31]));
					check_field("run_length", 32'(want.len), 32'(m_tdata[92:62]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
		end
		runs_due_count = runs_due.size();
	end

endmodule

@@ dv/tb_quantized_run_length_encoder_top.sv @@
`timescale 1ns / 1ps

module tb_quantized_run_length_encoder_top;
	import qre_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = COLORS_RESET;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic [FUNC_W-1:0]   s_tuser   = FUNC_SCAN;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [COLOR_W-1:0]  m_tuser;
	logic                m_tlast;

	int errors;
	int runs_due_count;
	int burst_left = 0;
	int sent_items = 0;
	int rx_tick    = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	quantized_run_length_encoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	qre_run_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.errors         (errors),
		.runs_due_count (runs_due_count)
	);

	// receiver: rotate between always ready, random, periodic and heavy stalls
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		case (rx_tick[8:7])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 2) != 0);
			2'd2: m_tready <= (rx_tick[3:0] < 4'd3);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// called and left at a falling edge; valid stays high between back-to-back requests
	task automatic send_req(logic [FUNC_W-1:0] func, logic [SAMPLE_W-1:0] value,
	                        logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {2'b00, col, row, value};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		burst_left--;
		if (func != FUNC_UNUSED)
			sent_items++;
	endtask

	task automatic drain_runs();
		s_tvalid <= 1'b0;
		while (runs_due_count != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// entries that extend a run emit nothing, so allow for the block to finish them
	task automatic settle();
		drain_runs();
		repeat (200) @(negedge clk);
	endtask

	task automatic set_colors(logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		#8_000_000;
		$display("quantized_run_length_encoder_top: mismatch");
		$finish;
	end

	initial begin
		logic [SAMPLE_W-1:0] ceiling;
		logic [SAMPLE_W-1:0] v;
		logic [IDX_W-1:0]    row;
		logic [IDX_W-1:0]    c0;
		int                  len;
		int                  base;
		int                  phase;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// flush with nothing open, entries before any maximum, unused code
		send_req(FUNC_FLUSH, '0, '0, '0);
		send_req(FUNC_ENTRY, 32'd5, '0, '0);
		send_req(FUNC_SCAN, '0, '0, '0);
		send_req(FUNC_ENTRY, 32'd5, '0, '0);
		send_req(FUNC_UNUSED, '1, '1, '1);
		// full-range maximum, extremes of value, row and column
		send_req(FUNC_SCAN, '1, '1, '1);
		send_req(FUNC_ENTRY, '0, '0, '0);
		send_req(FUNC_ENTRY, '0, '0, IDX_W'(1));
		send_req(FUNC_ENTRY, '0, '0, IDX_W'(2));
		send_req(FUNC_ENTRY, '1, LEN_MAX, LEN_MAX);
		// start + length reaches 2^31 and must not wrap onto column 0
		send_req(FUNC_ENTRY, '1, LEN_MAX, '0);
		send_req(FUNC_ENTRY, '0, IDX_W'(1), IDX_W'(3));
		send_req(FUNC_FLUSH, '0, '0, '0);
		// value above the maximum lands in the top color
		send_req(FUNC_SCAN, 32'd100, '0, '0);
		send_req(FUNC_ENTRY, 32'd200, '0, '0);
		send_req(FUNC_ENTRY, 32'd50, '0, '0);
		// zero colors act as one; open runs survive the register change
		settle();
		set_colors(7'd0);
		send_req(FUNC_SCAN, 32'd1000, '0, '0);
		send_req(FUNC_ENTRY, 32'd999, IDX_W'(2), IDX_W'(5));
		send_req(FUNC_ENTRY, 32'd1000, IDX_W'(2), IDX_W'(6));
		// count above the bin limit clamps
		settle();
		set_colors(7'd127);
		send_req(FUNC_ENTRY, 32'd500, IDX_W'(3), '0);
		send_req(FUNC_FLUSH, '0, '0, '0);
		settle();
		set_colors(7'd2);
		send_req(FUNC_SCAN, 32'd10, '0, '0);
		send_req(FUNC_ENTRY, 32'd9, '0, '0);
		send_req(FUNC_ENTRY, 32'd10, '0, '0);
		send_req(FUNC_FLUSH, '0, '0, '0);

		base  = sent_items;
		phase = 0;
		while (sent_items - base < 400) begin
			settle();
			case (phase)
				0: set_colors(7'd64);
				1: set_colors(7'd2);
				default: begin
					case ($urandom_range(0, 9))
						0: set_colors(7'd2);
						1: set_colors(7'd64);
						2: set_colors(7'd1);
						3: set_colors(7'd0);
						4: set_colors(CFG_W'($urandom_range(65, 127)));
						5: ;
						default: set_colors(CFG_W'($urandom_range(2, 64)));
					endcase
				end
			endcase
			case ($urandom_range(0, 2))
				0: ceiling = 32'd255;
				1: ceiling = 32'h000F_FFFF;
				default: ceiling = '1;
			endcase
			repeat ($urandom_range(1, 3))
				send_req(FUNC_SCAN, $urandom_range(0, ceiling), IDX_W'($urandom()),
				         IDX_W'($urandom()));
			for (int s = 0; s < $urandom_range(2, 10); s++) begin
				// hold the sender until every pending run is out
				if ((phase == 1 && s == 0) || $urandom_range(0, 11) == 0)
					drain_runs();
				row = ($urandom_range(0, 5) == 0) ? IDX_W'($urandom()) : IDX_W'($urandom_range(0, 3));
				case ($urandom_range(0, 7))
					0: c0 = LEN_MAX - IDX_W'($urandom_range(0, 3));
					1: c0 = IDX_W'($urandom());
					default: c0 = IDX_W'($urandom_range(0, 40));
				endcase
				v   = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, ceiling);
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					send_req(FUNC_ENTRY, v, row, c0 + IDX_W'(k));
					if ($urandom_range(0, 11) == 0) begin
						case ($urandom_range(0, 2))
							0: send_req(FUNC_UNUSED, $urandom(), IDX_W'($urandom()),
							            IDX_W'($urandom()));
							1: send_req(FUNC_ENTRY, $urandom(), IDX_W'($urandom()),
							            IDX_W'($urandom()));
							default: send_req(FUNC_SCAN, $urandom_range(0, ceiling), '0, '0);
						endcase
					end
				end
			end
			if ($urandom_range(0, 4) != 0)
				send_req(FUNC_FLUSH, $urandom(), IDX_W'($urandom()), IDX_W'($urandom()));
			phase++;
		end
		send_req(FUNC_FLUSH, '0, '0, '0);

		drain_runs();
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("quantized_run_length_encoder_top: match");
		else
			$display("quantized_run_length_encoder_top: mismatch");
		$finish;
	end

endmodule
